### hdl/positional_list_store_assert.svh
// assertion macros for the positional list store
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PLST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/plst_pkg.sv
// shared constants, types and codes for the positional list store
package plst_pkg;

   localparam int LIST_DEPTH = 64;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = 7;
   localparam int POS_W      = 7;
   localparam int OP_W       = 3;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_READ      = 3'd6
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_OOB   = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

### hdl/plst_req_if.sv
// request channel interface
interface plst_req_if import plst_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         opcode;
   logic signed [VAL_W-1:0] value;
   logic [POS_W-1:0]        position;

   modport source (output valid, output opcode, output value, output position, input ready);
   modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

### hdl/plst_rsp_if.sv
// response channel interface
interface plst_rsp_if import plst_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STAT_W-1:0]       status;
   logic signed [VAL_W-1:0] read_value;
   logic [CNT_W-1:0]        length;

   modport source (output valid, output status, output read_value, output length, input ready);
   modport sink (input valid, input status, input read_value, input length, output ready);
endinterface

### hdl/plst_ctrl.sv
// controller state machine: request intake, execute step, response valid
module plst_ctrl import plst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/plst_datapath.sv
// datapath: request registers, shifting row of entry cells, count and response registers
module plst_datapath import plst_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic [OP_W-1:0]         req_opcode,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]        req_position,
   output logic [STAT_W-1:0]       rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [CNT_W-1:0]        rsp_length
);

   logic [OP_W-1:0]         op_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              status_ff, status_in;
   logic signed [VAL_W-1:0] rdval_ff, rdval_in;
   logic signed [VAL_W-1:0] cell_q [LIST_DEPTH];

   logic             full, empty, ins_oob, acc_oob;
   logic             do_ins, do_rem, do_rd;
   logic [IDX_W-1:0] idx, pos_idx, cnt_idx, last_idx;
   logic [POS_W-1:0] pos_m1;
   logic [CNT_W:0]   pos_wide, cnt_wide;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
   end

   assign full     = (count_ff == CNT_W'(LIST_DEPTH));
   assign empty    = (count_ff == '0);
   assign pos_wide = {1'b0, pos_ff};
   assign cnt_wide = {1'b0, count_ff};
   assign ins_oob  = (pos_ff == '0) || (pos_wide > cnt_wide + (CNT_W+1)'(1));
   assign acc_oob  = (pos_ff == '0) || (pos_wide > cnt_wide);
   assign pos_m1   = pos_ff - POS_W'(1);
   assign pos_idx  = pos_m1[IDX_W-1:0];
   assign cnt_idx  = count_ff[IDX_W-1:0];
   assign last_idx = cnt_idx - IDX_W'(1);

   always_comb begin
      status_in = STAT_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      do_rd     = 1'b0;
      idx       = '0;
      unique case (op_ff)
         OP_INS_FRONT, OP_INS_END: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = (op_ff == OP_INS_FRONT) ? '0 : cnt_idx;
            end
         end
         OP_INS_POS: begin
            if (full) begin
               status_in = STAT_FULL;
            end else if (ins_oob) begin
               status_in = STAT_OOB;
            end else begin
               do_ins = 1'b1;
               idx    = pos_idx;
            end
         end
         OP_DEL_FIRST, OP_DEL_LAST: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               do_rem = 1'b1;
               idx    = (op_ff == OP_DEL_FIRST) ? '0 : last_idx;
            end
         end
         OP_DEL_POS, OP_READ: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else if (acc_oob) begin
               status_in = STAT_OOB;
            end else begin
               do_rem = (op_ff == OP_DEL_POS);
               do_rd  = (op_ff == OP_READ);
               idx    = pos_idx;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // row of cells; on insert or delete the cells from the index onward shift together
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] cell_ff, cell_in, prev_val, next_val;

      if (g == 0) begin : g_first
         assign prev_val = value_ff;
      end else begin : g_mid
         assign prev_val = cell_q[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_last
         assign next_val = cell_ff;
      end else begin : g_body
         assign next_val = cell_q[g+1];
      end

      always_comb begin
         cell_in = cell_ff;
         if (do_ins) begin
            if (IDX_W'(g) > idx) begin
               cell_in = prev_val;
            end else if (IDX_W'(g) == idx) begin
               cell_in = value_ff;
            end
         end else if (do_rem) begin
            if (IDX_W'(g) >= idx) begin
               cell_in = next_val;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.exec) begin
            cell_ff <= cell_in;
         end
      end

      assign cell_q[g] = cell_ff;
   end

   assign rdval_in = do_rd ? cell_q[idx] : '0;

   always_comb begin
      count_in = count_ff;
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         rdval_ff  <= rdval_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rdval_ff;
   assign rsp_length     = count_ff;

endmodule

### hdl/positional_list_store.sv
// top level of the positional list store
// Ordered list of up to 64 signed 32-bit entries held in a row of register cells.
// Each request inserts (front, end or one-based position), deletes (first, last or
// position) or reads at a position, and returns one response with a status, the read
// value and the list length afterwards. Each request is first registered, and then
// executed in a step in which the cells from its index onward shift at once and the
// response registers load. A new request is taken as soon as the previous response is
// taken or being taken, and none while one is executing. No clearing pass after reset.
module positional_list_store import plst_pkg::*; (
   input logic         clock,
   input logic         reset,
   plst_req_if.sink    req_chan,
   plst_rsp_if.source  rsp_chan
);

`include "positional_list_store_assert.svh"

   cmd_type cmd;

   plst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   plst_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_chan.opcode),
      .req_value      (req_chan.value),
      .req_position   (req_chan.position),
      .rsp_status     (rsp_chan.status),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_length     (rsp_chan.length)
   );

   `PLST_ASSERT_NOW(a_full_len, clock, reset, rsp_chan.valid && rsp_chan.status == STAT_FULL, rsp_chan.length == CNT_W'(LIST_DEPTH), "full status with short list")
   `PLST_ASSERT_NOW(a_empty_len, clock, reset, rsp_chan.valid && rsp_chan.status == STAT_EMPTY, rsp_chan.length == '0, "empty status with entries")
   `PLST_ASSERT_NEXT(a_busy, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready && cmd.exec, "request taken while executing")
   `PLST_ASSERT_NEXT(a_rsp, clock, reset, cmd.exec, rsp_chan.valid, "no response after execute")

endmodule
